FILE: rtl/sct_pkg.sv
package sct_pkg;

    localparam int TIMER_COUNT = 2;

    localparam int COUNT_W = 9;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [2:0]         mode_t;
    typedef logic [7:0]         byte_t;

    localparam mode_t MODE_ADDR_WRITE  = 3'd0;
    localparam mode_t MODE_DATA_WRITE  = 3'd1;
    localparam mode_t MODE_STATUS_READ = 3'd2;
    localparam mode_t MODE_DATA_READ   = 3'd3;
    localparam mode_t MODE_TICK        = 3'd4;

    localparam byte_t REG_TIMER0_RELOAD = 8'h02;
    localparam byte_t REG_TIMER1_RELOAD = 8'h03;
    localparam byte_t REG_TIMER_CONTROL = 8'h04;

    localparam int CTRL_RESET_BIT   = 7;
    localparam int CTRL_MASK0_BIT   = 6;

    localparam byte_t STATUS_IRQ     = 8'h80;
    localparam byte_t STATUS_TIMER0  = 8'h40;
    localparam byte_t DATA_READ_BYTE = 8'hFF;

    localparam count_t RELOAD_FULL = 9'd256;

endpackage

FILE: rtl/sound_chip_timer_pair.sv
// Timer and status section of an FM sound chip. Each input word is one bus access (address
// write, data write, status read, data read) or a tick event carrying a number of elapsed
// timer ticks, and each input word yields exactly one output word on read_byte: the status
// byte for a status read, 0xFF for a data read and zero otherwise. A word is registered on
// entry; the timer state is updated and the result computed from that register and held in
// an output register, and a new word is accepted in every cycle while the output side takes
// its words. The input side stalls only when its register is full and the output register is
// held by a stall.
module sound_chip_timer_pair
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sct_pkg::mode_t      mode,
    input  sct_pkg::byte_t      bus_byte,
    input  sct_pkg::byte_t      elapsed_ticks,
    output logic                out_valid,
    input  logic                out_stall,
    output sct_pkg::byte_t      read_byte
);
    import sct_pkg::*;

    logic   in_valid_reg;
    mode_t  mode_reg;
    byte_t  bus_byte_reg;
    byte_t  ticks_reg;

    logic   out_valid_reg;
    logic   out_valid_next;
    byte_t  read_byte_reg;
    byte_t  read_byte_next;

    byte_t  selected_reg;
    byte_t  selected_next;
    count_t reload_reg    [TIMER_COUNT];
    count_t reload_next   [TIMER_COUNT];
    count_t remaining_reg [TIMER_COUNT];
    count_t remaining_next[TIMER_COUNT];
    logic   [TIMER_COUNT-1:0] running_reg;
    logic   [TIMER_COUNT-1:0] running_next;
    logic   [TIMER_COUNT-1:0] masked_reg;
    logic   [TIMER_COUNT-1:0] masked_next;
    logic   [TIMER_COUNT-1:0] expired_reg;
    logic   [TIMER_COUNT-1:0] expired_next;

    logic   advance;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign read_byte = read_byte_reg;

    always_comb
    begin
        logic   on;
        count_t ticks_ext;
        on             = 1'b0;
        selected_next  = selected_reg;
        reload_next    = reload_reg;
        remaining_next = remaining_reg;
        running_next   = running_reg;
        masked_next    = masked_reg;
        expired_next   = expired_reg;
        read_byte_next = '0;
        ticks_ext      = {1'b0, ticks_reg};
        case (mode_reg)
            MODE_ADDR_WRITE:
            begin
                selected_next = bus_byte_reg;
            end
            MODE_DATA_WRITE:
            begin
                if (selected_reg == REG_TIMER0_RELOAD)
                begin
                    reload_next[0] = RELOAD_FULL - {1'b0, bus_byte_reg};
                end
                else if (selected_reg == REG_TIMER1_RELOAD)
                begin
                    reload_next[1] = RELOAD_FULL - {1'b0, bus_byte_reg};
                end
                else if (selected_reg == REG_TIMER_CONTROL)
                begin
                    if (bus_byte_reg[CTRL_RESET_BIT])
                    begin
                        for (int t = 0; t < TIMER_COUNT; t++)
                        begin
                            remaining_next[t] = reload_reg[t];
                            expired_next[t]   = running_reg[t] && (reload_reg[t] == '0);
                        end
                    end
                    else
                    begin
                        for (int t = 0; t < TIMER_COUNT; t++)
                        begin
                            on = bus_byte_reg[t];
                            if (on != running_reg[t])
                            begin
                                if (on)
                                begin
                                    remaining_next[t] = reload_reg[t];
                                end
                                running_next[t] = on;
                                if (on && !expired_reg[t] && remaining_next[t] == '0)
                                begin
                                    expired_next[t] = 1'b1;
                                end
                            end
                            masked_next[t] = bus_byte_reg[CTRL_MASK0_BIT - t];
                            if (masked_next[t])
                            begin
                                expired_next[t] = 1'b0;
                            end
                        end
                    end
                end
            end
            MODE_STATUS_READ:
            begin
                for (int t = 0; t < TIMER_COUNT; t++)
                begin
                    if (expired_reg[t] && !masked_reg[t])
                    begin
                        read_byte_next = read_byte_next | STATUS_IRQ | (STATUS_TIMER0 >> t);
                    end
                end
            end
            MODE_DATA_READ:
            begin
                read_byte_next = DATA_READ_BYTE;
            end
            MODE_TICK:
            begin
                for (int t = 0; t < TIMER_COUNT; t++)
                begin
                    if (running_reg[t] && !expired_reg[t])
                    begin
                        if (ticks_ext >= remaining_reg[t])
                        begin
                            expired_next[t] = 1'b1;
                        end
                        else
                        begin
                            remaining_next[t] = remaining_reg[t] - ticks_ext;
                        end
                    end
                end
            end
            default:
            begin
                read_byte_next = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            selected_reg  <= '0;
            running_reg   <= '0;
            masked_reg    <= '0;
            expired_reg   <= '0;
            for (int t = 0; t < TIMER_COUNT; t++)
            begin
                reload_reg[t]    <= RELOAD_FULL;
                remaining_reg[t] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                selected_reg  <= selected_next;
                running_reg   <= running_next;
                masked_reg    <= masked_next;
                expired_reg   <= expired_next;
                reload_reg    <= reload_next;
                remaining_reg <= remaining_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            mode_reg     <= mode;
            bus_byte_reg <= bus_byte;
            ticks_reg    <= elapsed_ticks;
        end
        if (advance)
        begin
            read_byte_reg <= read_byte_next;
        end
    end

    // The input side is held back only while the output register is full and stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held output word");

    // A nonzero result always carries the top status bit or is the data read pattern.
    a_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (read_byte == '0 || read_byte[7]))
        else $error("result word without its top bit set");

    for (genvar g = 0; g < TIMER_COUNT; g++)
    begin : g_timer_chk
        a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
            (reload_reg[g] != '0) && (reload_reg[g] <= RELOAD_FULL)
            && (remaining_reg[g] <= RELOAD_FULL))
            else $error("timer count out of range");
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sct_pkg::*;

    localparam int    RANDOM_WORDS   = 1400;
    localparam int    CYCLE_LIMIT    = 500000;
    localparam int    TAIL_CYCLES    = 10;
    localparam int    REPORT_LIMIT   = 10;
    localparam int    CTRL_MASK1_BIT = 5;
    localparam byte_t STATUS_TIMER1  = 8'h20;
    localparam mode_t MODE_UNDEF_LO  = 3'd5;
    localparam mode_t MODE_UNDEF_HI  = 3'd7;

    typedef struct packed {
        mode_t mode;
        byte_t data;
        byte_t ticks;
        logic  typed;
        byte_t result;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 26;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_STATUS_READ, 8'h00, 8'h00, 1'b1, 8'h00},
        '{MODE_DATA_READ,   8'h00, 8'h00, 1'b1, DATA_READ_BYTE},
        '{MODE_UNDEF_LO,    8'hFF, 8'hFF, 1'b1, 8'h00},
        '{MODE_UNDEF_HI,    8'h00, 8'hFF, 1'b1, 8'h00},
        '{MODE_ADDR_WRITE,  REG_TIMER0_RELOAD, 8'h00, 1'b1, 8'h00},
        '{MODE_DATA_WRITE,  8'h00, 8'h00, 1'b1, 8'h00},
        '{MODE_ADDR_WRITE,  REG_TIMER1_RELOAD, 8'h00, 1'b1, 8'h00},
        '{MODE_DATA_WRITE,  8'hFF, 8'h00, 1'b1, 8'h00},
        '{MODE_ADDR_WRITE,  REG_TIMER_CONTROL, 8'h00, 1'b1, 8'h00},
        '{MODE_DATA_WRITE,  8'h03, 8'h00, 1'b1, 8'h00},
        '{MODE_TICK,        8'h00, 8'h00, 1'b1, 8'h00},
        '{MODE_TICK,        8'h00, 8'hFF, 1'b1, 8'h00},
        '{MODE_STATUS_READ, 8'h00, 8'h00, 1'b0, 8'h00},
        '{MODE_TICK,        8'h00, 8'hFF, 1'b1, 8'h00},
        '{MODE_STATUS_READ, 8'h00, 8'h00, 1'b0, 8'h00},
        '{MODE_DATA_WRITE,  8'h00, 8'h00, 1'b1, 8'h00},
        '{MODE_DATA_WRITE,  8'h03, 8'h00, 1'b1, 8'h00},
        '{MODE_TICK,        8'h00, 8'h01, 1'b1, 8'h00},
        '{MODE_STATUS_READ, 8'h00, 8'h00, 1'b0, 8'h00},
        '{MODE_DATA_WRITE,  8'h63, 8'h00, 1'b1, 8'h00},
        '{MODE_STATUS_READ, 8'h00, 8'h00, 1'b0, 8'h00},
        '{MODE_DATA_WRITE,  8'h80, 8'h00, 1'b1, 8'h00},
        '{MODE_DATA_WRITE,  8'h03, 8'h00, 1'b1, 8'h00},
        '{MODE_ADDR_WRITE,  8'h10, 8'h00, 1'b1, 8'h00},
        '{MODE_DATA_WRITE,  8'h80, 8'h00, 1'b1, 8'h00},
        '{MODE_STATUS_READ, 8'h00, 8'h00, 1'b0, 8'h00}
    };

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    mode_t mode = MODE_ADDR_WRITE;
    byte_t bus_byte = 8'h00;
    byte_t elapsed_ticks = 8'h00;
    logic  out_valid;
    logic  out_stall = 1'b0;
    byte_t read_byte;

    logic  row_typed = 1'b0;
    byte_t row_result = 8'h00;
    logic  quiet_run = 1'b0;

    byte_t  selected_reg;
    count_t reload_val [TIMER_COUNT];
    count_t remain_val [TIMER_COUNT];
    logic   running [TIMER_COUNT];
    logic   masked [TIMER_COUNT];
    logic   expired [TIMER_COUNT];

    byte_t pending_bytes [$];
    int    mismatches = 0;
    int    words_in = 0;
    int    words_out = 0;
    int    flagged_status = 0;
    int    cycles = 0;

    sound_chip_timer_pair dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .bus_byte      (bus_byte),
        .elapsed_ticks (elapsed_ticks),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_byte     (read_byte)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d words outstanding", cycles,
                     pending_bytes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void timers_reset_state();
        selected_reg = 8'h00;
        for (int t = 0; t < TIMER_COUNT; t++)
        begin
            reload_val[t] = RELOAD_FULL;
            remain_val[t] = '0;
            running[t]    = 1'b0;
            masked[t]     = 1'b0;
            expired[t]    = 1'b0;
        end
    endfunction

    function automatic void expire_if_empty(input int t);
        if (running[t] && !expired[t] && remain_val[t] == '0)
            expired[t] = 1'b1;
    endfunction

    function automatic void apply_control(input byte_t v);
        if (v[CTRL_RESET_BIT])
        begin
            for (int t = 0; t < TIMER_COUNT; t++)
            begin
                remain_val[t] = reload_val[t];
                expired[t]    = 1'b0;
                expire_if_empty(t);
            end
        end
        else
        begin
            for (int t = 0; t < TIMER_COUNT; t++)
            begin
                if (v[t] != running[t])
                begin
                    if (v[t])
                        remain_val[t] = reload_val[t];
                    running[t] = v[t];
                    expire_if_empty(t);
                end
            end
            masked[0] = v[CTRL_MASK0_BIT];
            if (masked[0])
                expired[0] = 1'b0;
            masked[1] = v[CTRL_MASK1_BIT];
            if (masked[1])
                expired[1] = 1'b0;
        end
    endfunction

    function automatic byte_t timers_access(input mode_t m, input byte_t b, input byte_t ticks);
        byte_t status;
        status = 8'h00;
        case (m)
            MODE_ADDR_WRITE:
                selected_reg = b;
            MODE_DATA_WRITE:
            begin
                if (selected_reg == REG_TIMER0_RELOAD)
                    reload_val[0] = RELOAD_FULL - count_t'(b);
                else if (selected_reg == REG_TIMER1_RELOAD)
                    reload_val[1] = RELOAD_FULL - count_t'(b);
                else if (selected_reg == REG_TIMER_CONTROL)
                    apply_control(b);
            end
            MODE_STATUS_READ:
            begin
                if (expired[0] && !masked[0])
                    status = status | STATUS_IRQ | STATUS_TIMER0;
                if (expired[1] && !masked[1])
                    status = status | STATUS_IRQ | STATUS_TIMER1;
            end
            MODE_DATA_READ:
                status = DATA_READ_BYTE;
            MODE_TICK:
            begin
                for (int t = 0; t < TIMER_COUNT; t++)
                begin
                    if (running[t] && !expired[t])
                    begin
                        if (count_t'(ticks) >= remain_val[t])
                            expired[t] = 1'b1;
                        else
                            remain_val[t] = remain_val[t] - count_t'(ticks);
                    end
                end
            end
            default:
                status = 8'h00;
        endcase
        return status;
    endfunction

    function automatic void report_mismatch(input string what, input byte_t exp_b,
                                            input byte_t got_b);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("Mismatch (%s) at cycle %0d: read_byte expected %02h got %02h",
                     what, cycles, exp_b, got_b);
    endfunction

    always @(posedge clk)
    begin : scoreboard
        byte_t predicted;
        byte_t oldest;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted = timers_access(mode, bus_byte, elapsed_ticks);
                pending_bytes.push_back(row_typed ? row_result : predicted);
                words_in++;
            end
            if (out_valid && !out_stall)
            begin
                words_out++;
                if (pending_bytes.size() == 0)
                    report_mismatch("unexpected word", 8'h00, read_byte);
                else
                begin
                    oldest = pending_bytes.pop_front();
                    if (read_byte !== oldest)
                        report_mismatch("wrong value", oldest, read_byte);
                    if (read_byte[7] && read_byte != DATA_READ_BYTE)
                        flagged_status++;
                end
            end
        end
    end

    function automatic int burst_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int input_gap();
        if (quiet_run || $urandom_range(0, 99) < 55)
            return 0;
        return burst_len();
    endfunction

    initial
    begin : stall_driver
        int run;
        int len;
        forever
        begin
            run = $urandom_range(1, 40);
            repeat (run)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            if (!quiet_run)
            begin
                len = burst_len();
                repeat (len)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
        end
    end

    task automatic send_word(input mode_t m, input byte_t b, input byte_t ticks,
                             input logic typed, input byte_t result);
        int gap;
        gap = input_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        bus_byte      <= b;
        elapsed_ticks <= ticks;
        row_typed     <= typed;
        row_result    <= result;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int    r;
        mode_t m;
        byte_t b;
        byte_t ticks;
        timers_reset_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_word(DIRECTED[i].mode, DIRECTED[i].data, DIRECTED[i].ticks,
                      DIRECTED[i].typed, DIRECTED[i].result);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            quiet_run = (i >= 300 && i < 500);
            b     = byte_t'($urandom_range(0, 255));
            ticks = byte_t'($urandom_range(0, 255));
            r     = $urandom_range(0, 99);
            if (r < 28)
            begin
                m = MODE_ADDR_WRITE;
                r = $urandom_range(0, 9);
                if (r < 3)
                    b = REG_TIMER0_RELOAD;
                else if (r < 6)
                    b = REG_TIMER1_RELOAD;
                else if (r < 9)
                    b = REG_TIMER_CONTROL;
            end
            else if (r < 55)
            begin
                m = MODE_DATA_WRITE;
                r = $urandom_range(0, 9);
                if (r < 3)
                    b = byte_t'($urandom_range(8'hC0, 8'hFF));
                else if (r < 6)
                    b = b & 8'h63;
            end
            else if (r < 80)
            begin
                m = MODE_TICK;
                if ($urandom_range(0, 1) == 0)
                    ticks = byte_t'($urandom_range(0, 15));
            end
            else if (r < 92)
                m = MODE_STATUS_READ;
            else if (r < 96)
                m = MODE_DATA_READ;
            else
                m = mode_t'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
            send_word(m, b, ticks, 1'b0, 8'h00);
        end
        quiet_run = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending_bytes.size() != 0)
            report_mismatch("missing word", pending_bytes[0], 8'h00);
        $display("Sent %0d words (%0d directed) and checked %0d words on read_byte.",
                 words_in, DIRECTED_ROWS, words_out);
        $display("Status reads with a timer flag set: %0d; mismatches: %0d.",
                 flagged_status, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
